FILE: rtl/core/gk21_pkg.sv
package gk21_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Rule geometry and fixed-point formats
  localparam int         SLOTS     = 21;
  localparam logic [4:0] LAST_SLOT = 5'd20;
  localparam logic [4:0] CTR_LAST  = 5'd31;
  localparam logic [4:0] PASS_LAST = 5'd22;
  localparam logic [4:0] SCALE_LAST = 5'd4;
  localparam int         WBITS     = 30;
  localparam logic [63:0] DEC18    = 64'd1000000000000000000;
  localparam logic signed [63:0] ACC_LIM = 64'sh4000_0000_0000_0000;
  localparam logic [63:0] ERR_GAIN = 64'd200;

  // Convert an 18-digit decimal fraction to a rounded Q0.30 weight
  function automatic logic [29:0] dec_to_q30(input logic [63:0] d);
    logic [63:0] r;
    logic [31:0] q;
    logic [31:0] qr;
    r = d;
    q = '0;
    for (int i = 0; i < WBITS + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC18) begin
        q[0] = 1'b1;
        r    = r - DEC18;
      end
    end
    qr = (q + 32'd1) >> 1;
    return qr[29:0];
  endfunction

  // Kronrod weights, outermost abscissa first, centre last
  localparam logic [29:0] KRON_W [11] = '{
    dec_to_q30(64'd11694638867371874),  dec_to_q30(64'd32558162307964727),
    dec_to_q30(64'd54755896574351996),  dec_to_q30(64'd75039674810919953),
    dec_to_q30(64'd93125454583697606),  dec_to_q30(64'd109387158802297642),
    dec_to_q30(64'd123491976262065851), dec_to_q30(64'd134709217311473326),
    dec_to_q30(64'd142775938577060081), dec_to_q30(64'd147739104901338491),
    dec_to_q30(64'd149445554002916906)
  };

  // Gauss weights at the odd Kronrod positions
  localparam logic [29:0] GAUSS_W [5] = '{
    dec_to_q30(64'd66671344308688138),  dec_to_q30(64'd149451349150580593),
    dec_to_q30(64'd219086362515982044), dec_to_q30(64'd269266719309996355),
    dec_to_q30(64'd295524224714752870)
  };

  // Fold a slot onto its abscissa position
  function automatic logic [3:0] slot_pos(input logic [4:0] s);
    logic [4:0] p;
    p = (s <= 5'd10) ? s : (LAST_SLOT - s);
    return p[3:0];
  endfunction

  function automatic logic [29:0] kron_w(input logic [4:0] s);
    logic [3:0] p;
    p = slot_pos(s);
    return (p <= 4'd10) ? KRON_W[p] : '0;
  endfunction

  function automatic logic [29:0] gauss_w(input logic [4:0] s);
    logic [3:0] p;
    logic [3:0] g;
    p = slot_pos(s);
    g = (p - 4'd1) >> 1;
    if (p >= 4'd10 || !p[0]) return '0;
    return GAUSS_W[g[2:0]];
  endfunction

  // Multiplier operand selection, also tags the product for its write-back
  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_LOAD_K,
    MOP_LOAD_G,
    MOP_PASS,
    MOP_INT,
    MOP_ABS,
    MOP_ASC,
    MOP_ERR,
    MOP_RHI,
    MOP_RLO
  } mop_t;

  typedef struct packed {
    logic       load;
    mop_t       mop;
    logic       rd_en;
    logic [4:0] rd_addr;
    logic       asc_clr;
    logic       prep;
    logic       rs_init;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       rs_fin;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic close;
    logic rs_early;
    logic rs_big;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/gauss_kronrod_21_rule.sv
// 21-point Gauss-Kronrod quadrature over one interval.
// Input stream: one word per sample. in_tdata carries the sample value and
// the half-width of the interval, in_tuser the slot index 0..20. Slot 20
// closes the interval. Words with a slot above 20 are taken and dropped.
// Result stream: one word per closed interval, with the Kronrod integral,
// rescaled error estimate, absolute and deviation integrals, and a clip flag.
// Each sample is accepted with its Kronrod product, then takes its Gauss
// product on the shared multiplier and ends in S_LD_END before the next
// word is taken. The closing sample then sweeps the sample store once (one
// RAM read a cycle), scales the four sums and runs the rescale: a restoring
// divide, a square root and a final product, skipped when the error rescale
// is decided early.
// Reset clears the Kronrod, Gauss and absolute sums, the held width and
// the output valid; the sample store is not cleared. The result waits in
// an output register; the next interval is accepted meanwhile, and a new
// result holds off until the previous one has been taken.
module gauss_kronrod_21_rule import gk21_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // sample_value [31:0], half_width [63:32]
  input  logic [4:0]   in_tuser,   // sample_index [4:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // integral [31:0], error_estimate [62:32],
                                   // abs_integral [93:63], asc_deviation [124:94]
  output logic         out_tuser   // saturated [0]
);

  localparam int SW = (SAMPLE_BITS > 32) ? 32 : SAMPLE_BITS;

  cmd_t cmd;
  sts_t sts;

  gk21_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gk21_dpath #(
    .SW        (SW),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/core/gk21_ram.sv
module gk21_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 21
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/gk21_dpath.sv
module gk21_dpath import gk21_pkg::*; #(
  parameter int SW        = 32,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [63:0]  in_tdata,
  input  logic [4:0]   in_tuser,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  logic         out_tready,
  output logic         out_tvalid,
  output logic [127:0] out_tdata,
  output logic         out_tuser
);

  localparam int SHX = 32 - SW;
  localparam logic [63:0] POS_LIM = (64'd1 << (SW - 1)) - 64'd1;
  localparam logic [63:0] NEG_LIM = 64'd1 << (SW - 1);

  function automatic logic signed [31:0] sext(input logic [31:0] x);
    return ($signed(x) <<< SHX) >>> SHX;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // Shift right, rounding half away from zero on a magnitude
  function automatic logic [63:0] rshu(input logic [63:0] m, input int s);
    return (m >> s) + ((m >> (s - 1)) & 64'd1);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] t;
    t = a + b;
    if (t > ACC_LIM) begin
      t = ACC_LIM;
    end else if (t < -ACC_LIM) begin
      t = -ACC_LIM;
    end
    return t;
  endfunction

  // Product scaled by the fraction width, pinned at all-ones on overflow
  function automatic logic [63:0] mulsh(input logic [65:0] p);
    if (|p[65:64]) return '1;
    return rshu(p[63:0], FRAC_BITS);
  endfunction

  // Clip to the unsigned output range; bit 31 flags a clip
  function automatic logic [31:0] clip31(input logic [63:0] v);
    logic [63:0] c;
    c = (v > POS_LIM) ? POS_LIM : v;
    return {v > POS_LIM, c[30:0]};
  endfunction

  logic signed [31:0] in_val;
  logic [31:0]        in_mag;
  logic [31:0]        vmag_r;
  logic               vneg_r;
  logic [4:0]         idx_r;
  logic signed [31:0] width_r;
  logic [31:0]        ram_q;
  logic [4:0]         rd_idx_r;

  logic signed [63:0] kron_acc_r, gauss_acc_r, abs_acc_r;
  logic [63:0]        asc_acc_r;
  logic [63:0]        kmag, kred;
  logic signed [32:0] mean_r;
  logic signed [33:0] diff;
  logic [32:0]        pmag;

  logic [33:0] ma;
  logic [31:0] mb;
  logic [65:0] prod_r;
  mop_t        dst_r;
  logic signed [63:0] sprod;

  logic [32:0] ksm_r;
  logic        ks_neg_r;
  logic [31:0] hm_r;
  logic        hneg_r;
  logic [33:0] dmr_r, absr_r, ascr_r;
  logic [63:0] dm;
  logic [63:0] im_r, absv_r, ascv_r, errv_r;

  logic [3:0]  sh_v, sh_r;
  logic [63:0] e200_v, e200_r;
  logic [55:0] an_r, rr_r;
  logic [31:0] t_r;
  logic [56:0] rs;
  logic [63:0] sx_r, sres_r, sbit_r, sq_sum;
  logic [63:0] hi_r, lo_r, res_r;

  logic        out_valid_r;
  logic [127:0] out_data_r;
  logic        out_sat_r;
  logic [31:0] o_int, o_err, o_abs, o_asc;
  logic [63:0] o_im;
  logic        o_sat;

  // Decode the incoming word
  assign in_val = sext(in_tdata[31:0]);
  assign in_mag = 32'(0) - ((in_val[31]) ? 32'(in_val) : 32'(-in_val));

  // Sample store
  gk21_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (in_tuser),
    .wdata (in_val),
    .raddr (cmd.rd_addr),
    .rdata (ram_q)
  );

  // Latch the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= '0;
    end else if (cmd.load) begin
      width_r <= sext(in_tdata[63:32]);
    end
    if (cmd.load) begin
      vmag_r <= in_mag;
      vneg_r <= in_val[31];
      idx_r  <= in_tuser;
    end
    if (cmd.rd_en) begin
      rd_idx_r <= cmd.rd_addr;
    end
  end

  // Mean of the closing interval and deviation of the stored sample
  assign kmag = mag64(kron_acc_r);
  assign kred = rshu(kmag, WBITS + 1);
  assign diff = 34'($signed(ram_q)) - 34'(mean_r);
  assign pmag = diff[33] ? 33'(-diff) : 33'(diff);

  always_ff @(posedge clk) begin
    mean_r <= kron_acc_r[63] ? -$signed({1'b0, kred[31:0]}) : $signed({1'b0, kred[31:0]});
  end

  // Select multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mop)
      MOP_LOAD_K: begin ma = 34'(in_mag); mb = 32'(kron_w(in_tuser)); end
      MOP_LOAD_G: begin ma = 34'(vmag_r); mb = 32'(gauss_w(idx_r)); end
      MOP_PASS:   begin ma = 34'(pmag); mb = 32'(kron_w(rd_idx_r)); end
      MOP_INT:    begin ma = 34'(ksm_r); mb = hm_r; end
      MOP_ABS:    begin ma = absr_r; mb = hm_r; end
      MOP_ASC:    begin ma = ascr_r; mb = hm_r; end
      MOP_ERR:    begin ma = dmr_r; mb = hm_r; end
      MOP_RHI:    begin ma = 34'(e200_r[63:32]); mb = sres_r[31:0]; end
      MOP_RLO:    begin ma = 34'(e200_r[31:0]); mb = sres_r[31:0]; end
      default:    begin ma = '0; mb = '0; end
    endcase
  end

  // Multiply, tag the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r <= MOP_NONE;
    end else begin
      dst_r <= cmd.mop;
    end
    prod_r <= 66'(ma) * 66'(mb);
  end

  assign sprod = vneg_r ? -$signed(prod_r[63:0]) : $signed(prod_r[63:0]);

  // Write back products into sums and scaled results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kron_acc_r  <= '0;
      gauss_acc_r <= '0;
      abs_acc_r   <= '0;
    end else if (cmd.out_load) begin
      kron_acc_r  <= '0;
      gauss_acc_r <= '0;
      abs_acc_r   <= '0;
    end else begin
      if (dst_r == MOP_LOAD_K) begin
        kron_acc_r <= sat_add(kron_acc_r, sprod);
        abs_acc_r  <= sat_add(abs_acc_r, $signed(prod_r[63:0]));
      end
      if (dst_r == MOP_LOAD_G) begin
        gauss_acc_r <= sat_add(gauss_acc_r, sprod);
      end
    end
    if (cmd.asc_clr) begin
      asc_acc_r <= '0;
    end else if (dst_r == MOP_PASS) begin
      asc_acc_r <= asc_acc_r + prod_r[63:0];
    end
    case (dst_r)
      MOP_INT: im_r   <= mulsh(prod_r);
      MOP_ABS: absv_r <= mulsh(prod_r);
      MOP_ASC: ascv_r <= mulsh(prod_r);
      MOP_ERR: errv_r <= mulsh(prod_r);
      MOP_RHI: hi_r   <= prod_r[63:0];
      MOP_RLO: lo_r   <= 64'(prod_r[63:32]);
      default: ;
    endcase
  end

  // Reduce the sums to sample units
  assign dm = (kron_acc_r >= gauss_acc_r) ? 64'(kron_acc_r - gauss_acc_r)
                                          : 64'(gauss_acc_r - kron_acc_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ksm_r    <= 33'(rshu(kmag, WBITS));
      ks_neg_r <= kron_acc_r[63] && (rshu(kmag, WBITS) != 64'd0);
      hm_r     <= 32'(mag64(64'(width_r)));
      hneg_r   <= width_r[31];
      dmr_r    <= 34'(rshu(dm, WBITS));
      absr_r   <= 34'(rshu(64'(abs_acc_r), WBITS));
      ascr_r   <= 34'(rshu(asc_acc_r, WBITS));
    end
  end

  // Normalise the rescale operands
  always_comb begin
    sh_v = '0;
    for (int i = 56; i < 64; i++) begin
      if (ascv_r[i]) sh_v = 4'(i - 55);
    end
    e200_v = 64'((errv_r >> sh_v) * ERR_GAIN);
  end

  assign rs     = {rr_r, 1'b0};
  assign sq_sum = sres_r + sbit_r;

  // Rescale: divide, root, final product
  always_ff @(posedge clk) begin
    if (cmd.rs_init) begin
      res_r  <= (errv_r == '0 || ascv_r == '0) ? errv_r : ascv_r;
      sh_r   <= sh_v;
      an_r   <= 56'(ascv_r >> sh_v);
      e200_r <= e200_v;
      rr_r   <= 56'(e200_v);
      t_r    <= '0;
    end
    if (cmd.div_step) begin
      if (rs >= 57'(an_r)) begin
        rr_r <= 56'(rs - 57'(an_r));
        t_r  <= {t_r[30:0], 1'b1};
      end else begin
        rr_r <= rs[55:0];
        t_r  <= {t_r[30:0], 1'b0};
      end
    end
    if (cmd.sqrt_init) begin
      sx_r   <= {t_r, 32'd0};
      sres_r <= '0;
      sbit_r <= 64'h4000_0000_0000_0000;
    end
    if (cmd.sqrt_step) begin
      if (sx_r >= sq_sum) begin
        sx_r   <= sx_r - sq_sum;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
    if (cmd.rs_fin) begin
      res_r <= (hi_r + lo_r) << sh_r;
    end
  end

  // Saturate the results
  always_comb begin
    o_sat = 1'b0;
    o_im  = im_r;
    if (im_r == '0) begin
      o_int = '0;
    end else if (ks_neg_r != hneg_r) begin
      if (im_r > NEG_LIM) begin
        o_im  = NEG_LIM;
        o_sat = 1'b1;
      end
      o_int = 32'(64'd0 - o_im);
    end else begin
      if (im_r > POS_LIM) begin
        o_im  = POS_LIM;
        o_sat = 1'b1;
      end
      o_int = o_im[31:0];
    end
    o_err = clip31(res_r);
    o_abs = clip31(absv_r);
    o_asc = clip31(ascv_r);
    o_sat = o_sat | o_err[31] | o_abs[31] | o_asc[31];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= {3'd0, o_asc[30:0], o_abs[30:0], o_err[30:0], o_int};
      out_sat_r  <= o_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // Status to the controller
  assign sts.idx_ok   = (in_tuser <= LAST_SLOT);
  assign sts.close    = (idx_r == LAST_SLOT);
  assign sts.rs_early = (errv_r == '0) || (ascv_r == '0) || (errv_r >= ascv_r);
  assign sts.rs_big   = (e200_r >= 64'(an_r));
  assign sts.out_free = !out_valid_r || out_tready;

`ifndef SYNTHESIS
  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("result not presented after load");
`endif

endmodule

FILE: rtl/core/gk21_ctrl.sv
module gk21_ctrl import gk21_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'b0000_0000_0000_0001,
    S_LD_G    = 16'b0000_0000_0000_0010,
    S_LD_END  = 16'b0000_0000_0000_0100,
    S_PASS    = 16'b0000_0000_0000_1000,
    S_PREP    = 16'b0000_0000_0001_0000,
    S_SCALE   = 16'b0000_0000_0010_0000,
    S_RS_INIT = 16'b0000_0000_0100_0000,
    S_RS_CMP  = 16'b0000_0000_1000_0000,
    S_RS_DIV  = 16'b0000_0001_0000_0000,
    S_RS_SQI  = 16'b0000_0010_0000_0000,
    S_RS_SQRT = 16'b0000_0100_0000_0000,
    S_RS_HI   = 16'b0000_1000_0000_0000,
    S_RS_LO   = 16'b0001_0000_0000_0000,
    S_RS_SUM  = 16'b0010_0000_0000_0000,
    S_RS_FIN  = 16'b0100_0000_0000_0000,
    S_OUT     = 16'b1000_0000_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequence one item, then the closing computation
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && sts.idx_ok) begin
          cmd.load  = 1'b1;
          cmd.mop   = MOP_LOAD_K;
          state_nxt = S_LD_G;
        end
      end
      S_LD_G: begin
        cmd.mop   = MOP_LOAD_G;
        state_nxt = S_LD_END;
      end
      S_LD_END: begin
        state_nxt = sts.close ? S_PASS : S_IDLE;
      end
      S_PASS: begin
        cmd.rd_en   = (cnt_r < 5'(SLOTS));
        cmd.rd_addr = cnt_r;
        cmd.asc_clr = (cnt_r == '0);
        if (cnt_r != '0 && cnt_r <= 5'(SLOTS)) cmd.mop = MOP_PASS;
        if (cnt_r == PASS_LAST) begin
          state_nxt = S_PREP;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        case (cnt_r)
          5'd0:    cmd.mop = MOP_INT;
          5'd1:    cmd.mop = MOP_ABS;
          5'd2:    cmd.mop = MOP_ASC;
          5'd3:    cmd.mop = MOP_ERR;
          default: cmd.mop = MOP_NONE;
        endcase
        if (cnt_r == SCALE_LAST) begin
          state_nxt = S_RS_INIT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_RS_INIT: begin
        cmd.rs_init = 1'b1;
        state_nxt   = sts.rs_early ? S_OUT : S_RS_CMP;
      end
      S_RS_CMP: begin
        state_nxt = sts.rs_big ? S_OUT : S_RS_DIV;
      end
      S_RS_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CTR_LAST) begin
          state_nxt = S_RS_SQI;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_RS_SQI: begin
        cmd.sqrt_init = 1'b1;
        state_nxt     = S_RS_SQRT;
      end
      S_RS_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == CTR_LAST) begin
          state_nxt = S_RS_HI;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_RS_HI: begin
        cmd.mop   = MOP_RHI;
        state_nxt = S_RS_LO;
      end
      S_RS_LO: begin
        cmd.mop   = MOP_RLO;
        state_nxt = S_RS_SUM;
      end
      S_RS_SUM: begin
        state_nxt = S_RS_FIN;
      end
      S_RS_FIN: begin
        cmd.rs_fin = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");
  a_ld_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD_G) |-> $past(in_tvalid && in_tready))
    else $error("load step without an accepted word");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule
